>>> rtl/lz78e_pkg.sv
package lz78e_pkg;

    // field widths
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 13;
    localparam int KEY_W   = CODE_W + SYM_W;

    // dictionary organization
    localparam int EPOCH_W          = 8;
    localparam int NUM_CELLS        = 8;
    localparam int COL_W            = $clog2(NUM_CELLS);
    localparam int MAX_CODE         = 8190;
    localparam int LZE_DICT_ENTRIES = 4096;

    localparam logic [CODE_W-1:0]  CODE_LIMIT_RST = CODE_W'(4096);
    localparam logic [CODE_W-1:0]  CODE_FIRST     = CODE_W'(1);
    localparam logic [31:0]        HASH_MULT      = 32'h9E37_79B1;
    localparam logic [EPOCH_W-1:0] EPOCH_NONE     = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST    = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST     = '1;

    // one dictionary slot as stored in a bank
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
    } t_entry;

    // probe result travelling along the row of cells
    typedef struct packed {
        logic              resolved;
        logic              hit;
        logic [CODE_W-1:0] code;
        logic [COL_W-1:0]  col;
    } t_chain;

    // broadcast search controls
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [EPOCH_W-1:0] epoch;
        logic [COL_W-1:0]   start_col;
        logic               first_round;
        logic               last_round;
    } t_probe;

    // broadcast write controls
    typedef struct packed {
        logic              ins_we;
        logic [COL_W-1:0]  ins_col;
        logic [CODE_W-1:0] ins_code;
        logic              clr_we;
    } t_wr;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE
    } t_state;

    // multiplicative hash, top bits are used as slot index
    function automatic logic [31:0] hash_key(input logic [KEY_W-1:0] key);
        logic [31:0] prod;
        prod = 32'(key) * HASH_MULT;
        return prod;
    endfunction

endpackage

>>> rtl/lz78e_ifs.sv
interface lz78e_sym_if
    import lz78e_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface lz78e_pair_if
    import lz78e_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] prefix_code;
    logic [SYM_W-1:0]  next_symbol;
    logic              flush_pair;
    logic              string_end;
    logic              dict_full;

    modport source (
        output valid, output prefix_code, output next_symbol,
        output flush_pair, output string_end, output dict_full, input ready
    );
    modport sink (
        input valid, input prefix_code, input next_symbol,
        input flush_pair, input string_end, input dict_full, output ready
    );
endinterface

>>> rtl/lz78e_ram.sv
module lz78e_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/lz78e_cell.sv
module lz78e_cell
    import lz78e_pkg::*;
#(
    parameter int CELL_ID = 0,
    parameter int ROWS    = 512
) (
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic [$clog2(ROWS)-1:0] i_raddr,
    input  logic [$clog2(ROWS)-1:0] i_waddr,
    input  t_probe                  i_probe,
    input  t_wr                     i_wr,
    input  t_chain                  i_chain,
    output t_chain                  o_chain
);
    localparam logic [COL_W-1:0] MY_COL = COL_W'(CELL_ID);

    t_entry rd_entry;
    t_entry wr_entry;
    logic   wr_en;
    logic   unmasked;
    logic   empty;
    logic   match;

    // this cell owns every slot whose low index bits equal its column
    assign wr_en = i_wr.clr_we || (i_wr.ins_we && (i_wr.ins_col == MY_COL));

    always_comb begin
        if (i_wr.clr_we) begin
            wr_entry = '{epoch: EPOCH_NONE, key: '0, code: '0};
        end else begin
            wr_entry = '{epoch: i_probe.epoch, key: i_probe.key, code: i_wr.ins_code};
        end
    end

    lz78e_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ROWS)
    ) u_bank (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_waddr),
        .i_wdata (wr_entry),
        .i_re    (i_rd_en),
        .i_raddr (i_raddr),
        .o_rdata (rd_entry)
    );

    // first row starts at the hashed column, the wrap-around row ends before it
    assign unmasked = (!i_probe.first_round || (MY_COL >= i_probe.start_col)) &&
                      (!i_probe.last_round  || (MY_COL <  i_probe.start_col));
    assign empty    = (rd_entry.epoch != i_probe.epoch);
    assign match    = !empty && (rd_entry.key == i_probe.key);

    always_comb begin
        o_chain = i_chain;
        if (!i_chain.resolved && unmasked && (empty || match)) begin
            o_chain = '{resolved: 1'b1, hit: match, code: rd_entry.code, col: MY_COL};
        end
    end
endmodule

>>> rtl/lz78_encoder_unit.sv
// lz78 encoder, one byte per input transaction
// i_sym_ch carries symbol and last_symbol; o_pair_ch carries one
// (prefix_code, next_symbol) pair with flush_pair, string_end and dict_full.
// i_cfg_we / i_cfg_wdata write code_limit; the user writes it only while the
// block is idle, and the block itself leaves this unchecked. a byte is taken in
// ST_IDLE, hashed in ST_HASH and probed row by row in ST_PROBE by linear
// probing; the pair is registered and shows on o_pair_ch the cycle after that.
// the dictionary is a hash table spread over a row of 8 cells, one ram bank
// each; one row of 8 slots is read per cycle and the cells resolve the first
// empty or matching slot in probe order along their chain.
// entries carry an epoch tag: string end bumps the epoch instead of clearing.
// after reset, and after every 255th string end, a clearing pass writes the
// whole table, one row per cycle, DICT_ENTRIES rounded up to a power of two
// slots in all, while i_sym_ch.ready stays low.
// a stalled o_pair_ch holds its pair; the block still takes the next byte and
// works on it, and waits with its own result until the output register frees.
module lz78_encoder_unit
    import lz78e_pkg::*;
#(
    parameter int DICT_ENTRIES = LZE_DICT_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CODE_W-1:0] i_cfg_wdata,
    lz78e_sym_if.sink         i_sym_ch,
    lz78e_pair_if.source      o_pair_ch
);
    // table geometry
    localparam int SLOT_W   = $clog2(DICT_ENTRIES);
    localparam int SLOTS    = 2 ** SLOT_W;
    localparam int ROWS     = SLOTS / NUM_CELLS;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int RND_W    = $clog2(ROWS + 1);
    localparam int CODE_CAP = (DICT_ENTRIES < MAX_CODE) ? DICT_ENTRIES : MAX_CODE;
    localparam logic [CODE_W-1:0] CODE_CAP_C = CODE_W'(CODE_CAP);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [RND_W-1:0]  RND_LAST   = RND_W'(ROWS);

    // control state
    t_state             r_state,      n_state;
    logic [ROW_W-1:0]   r_clr_row,    n_clr_row;
    logic [EPOCH_W-1:0] r_epoch,      n_epoch;
    logic [CODE_W-1:0]  r_code_limit, n_code_limit;
    logic [CODE_W-1:0]  r_match,      n_match;
    logic [CODE_W-1:0]  r_next_free,  n_next_free;
    logic               r_out_valid,  n_out_valid;
    logic [RND_W-1:0]   r_round,      n_round;

    // item in flight
    logic [KEY_W-1:0]   r_key,        n_key;
    logic               r_last,       n_last;
    logic [ROW_W-1:0]   r_row,        n_row;
    logic [COL_W-1:0]   r_start_col,  n_start_col;

    // output register
    logic [CODE_W-1:0]  r_prefix,     n_prefix;
    logic [SYM_W-1:0]   r_next_sym,   n_next_sym;
    logic               r_flush,      n_flush;
    logic               r_end,        n_end;
    logic               r_full,       n_full;

    // cell row
    logic               rd_en;
    logic [ROW_W-1:0]   raddr;
    logic [ROW_W-1:0]   waddr;
    t_probe             probe;
    t_wr                wr;
    t_chain             chain [NUM_CELLS+1];

    logic [31:0]        hash;
    logic [SLOT_W-1:0]  slot;
    logic               out_free;
    logic               done;
    logic               hit;
    logic               can_add;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++) begin : gen_cell
            lz78e_cell #(
                .CELL_ID (g),
                .ROWS    (ROWS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rd_en (rd_en),
                .i_raddr (raddr),
                .i_waddr (waddr),
                .i_probe (probe),
                .i_wr    (wr),
                .i_chain (chain[g]),
                .o_chain (chain[g+1])
            );
        end
    endgenerate

    assign hash = hash_key(r_key);
    assign slot = hash[31 -: SLOT_W];

    assign probe = '{
        key:         r_key,
        epoch:       r_epoch,
        start_col:   r_start_col,
        first_round: (r_round == '0),
        last_round:  (r_round == RND_LAST)
    };

    assign out_free = !r_out_valid || o_pair_ch.ready;
    // probe ends on the first empty or matching slot, or after a full lap
    assign done     = chain[NUM_CELLS].resolved || (r_round == RND_LAST);
    assign hit      = chain[NUM_CELLS].resolved && chain[NUM_CELLS].hit;
    assign can_add  = chain[NUM_CELLS].resolved &&
                      (r_next_free <= r_code_limit) && (r_next_free <= CODE_CAP_C);

    always_comb begin
        n_state      = r_state;
        n_clr_row    = r_clr_row;
        n_epoch      = r_epoch;
        n_code_limit = i_cfg_we ? i_cfg_wdata : r_code_limit;
        n_match      = r_match;
        n_next_free  = r_next_free;
        n_out_valid  = r_out_valid && !o_pair_ch.ready;
        n_round      = r_round;
        n_key        = r_key;
        n_last       = r_last;
        n_row        = r_row;
        n_start_col  = r_start_col;
        n_prefix     = r_prefix;
        n_next_sym   = r_next_sym;
        n_flush      = r_flush;
        n_end        = r_end;
        n_full       = r_full;

        rd_en        = 1'b0;
        raddr        = r_row;
        waddr        = r_row;
        wr           = '{ins_we: 1'b0, ins_col: chain[NUM_CELLS].col,
                         ins_code: r_next_free, clr_we: 1'b0};

        unique case (r_state)
            ST_CLEAR: begin
                wr.clr_we = 1'b1;
                waddr     = r_clr_row;
                n_clr_row = r_clr_row + ROW_W'(1);
                if (r_clr_row == ROW_LAST) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_sym_ch.valid) begin
                    n_key   = {r_match, i_sym_ch.symbol};
                    n_last  = i_sym_ch.last_symbol;
                    n_state = ST_HASH;
                end
            end

            ST_HASH: begin
                // hash result drives the bank read address directly
                n_row       = slot[SLOT_W-1:COL_W];
                n_start_col = slot[COL_W-1:0];
                n_round     = '0;
                rd_en       = 1'b1;
                raddr       = slot[SLOT_W-1:COL_W];
                n_state     = ST_PROBE;
            end

            ST_PROBE: begin
                if (!done) begin
                    // next row of slots, wrapping around the table
                    n_row   = r_row + ROW_W'(1);
                    n_round = r_round + RND_W'(1);
                    rd_en   = 1'b1;
                    raddr   = r_row + ROW_W'(1);
                end else if (hit && !r_last) begin
                    // match grows, nothing to send
                    n_match = chain[NUM_CELLS].code;
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (hit) begin
                        // pending match flushed at string end
                        n_prefix   = chain[NUM_CELLS].code;
                        n_next_sym = '0;
                        n_flush    = 1'b1;
                        n_end      = 1'b1;
                        n_full     = 1'b0;
                    end else begin
                        n_prefix   = r_match;
                        n_next_sym = r_key[SYM_W-1:0];
                        n_flush    = 1'b0;
                        n_end      = r_last;
                        n_full     = !can_add;
                        n_match    = '0;
                        if (can_add) begin
                            wr.ins_we   = 1'b1;
                            n_next_free = r_next_free + CODE_W'(1);
                        end
                    end
                    if (r_last) begin
                        // retire the dictionary by moving to a fresh epoch
                        n_match     = '0;
                        n_next_free = CODE_FIRST;
                        if (r_epoch == EPOCH_LAST) begin
                            n_epoch   = EPOCH_FIRST;
                            n_clr_row = '0;
                            n_state   = ST_CLEAR;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                        end
                    end
                end else begin
                    // output register busy: keep the row on the bank outputs
                    rd_en = 1'b1;
                    raddr = r_row;
                end
            end

            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state machine register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row    <= '0;
            r_epoch      <= EPOCH_FIRST;
            r_code_limit <= CODE_LIMIT_RST;
            r_match      <= '0;
            r_next_free  <= CODE_FIRST;
            r_out_valid  <= 1'b0;
            r_round      <= '0;
        end else begin
            r_clr_row    <= n_clr_row;
            r_epoch      <= n_epoch;
            r_code_limit <= n_code_limit;
            r_match      <= n_match;
            r_next_free  <= n_next_free;
            r_out_valid  <= n_out_valid;
            r_round      <= n_round;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_last      <= n_last;
        r_row       <= n_row;
        r_start_col <= n_start_col;
        r_prefix    <= n_prefix;
        r_next_sym  <= n_next_sym;
        r_flush     <= n_flush;
        r_end       <= n_end;
        r_full      <= n_full;
    end

    assign i_sym_ch.ready        = (r_state == ST_IDLE);
    assign o_pair_ch.valid       = r_out_valid;
    assign o_pair_ch.prefix_code = r_prefix;
    assign o_pair_ch.next_symbol = r_next_sym;
    assign o_pair_ch.flush_pair  = r_flush;
    assign o_pair_ch.string_end  = r_end;
    assign o_pair_ch.dict_full   = r_full;
endmodule

>>> rtl/lz78e_checker.sv
module lz78e_checker
    import lz78e_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CODE_W-1:0] i_prefix_code,
    input logic [SYM_W-1:0]  i_next_symbol,
    input logic              i_flush_pair,
    input logic              i_string_end,
    input logic              i_dict_full
);
    // a stalled pair holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_prefix_code) && $stable(i_next_symbol) &&
            $stable(i_flush_pair) && $stable(i_string_end) && $stable(i_dict_full))
        else $error("pair changed while stalled");

    // one byte at a time: lookup keeps the input closed after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken on back-to-back cycles");

    // reset starts the clearing pass, input stays closed
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input open right after reset");

    // a new pair is loaded only from the probe, never while idle
    a_pair_from_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("pair appeared without a lookup");
endmodule

bind lz78_encoder_unit lz78e_checker u_lz78e_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_sym_ch.valid),
    .i_in_ready    (i_sym_ch.ready),
    .i_out_valid   (o_pair_ch.valid),
    .i_out_ready   (o_pair_ch.ready),
    .i_prefix_code (o_pair_ch.prefix_code),
    .i_next_symbol (o_pair_ch.next_symbol),
    .i_flush_pair  (o_pair_ch.flush_pair),
    .i_string_end  (o_pair_ch.string_end),
    .i_dict_full   (o_pair_ch.dict_full)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import lz78e_pkg::*;

    // run length and timing knobs
    // full row walk or clear pass
    localparam int          SETTLE_CYCLES = LZE_DICT_ENTRIES / 8 + 64;
    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int          MAX_GAP       = 30;
    localparam int          RANDOM_ITEMS  = 300;
    localparam int          MIN_STRINGS   = 270;  // enough string ends to wrap the epoch once
    localparam int          STRINGS_PER_PHASE = 8;

    // one output pair as the block reports it
    typedef struct packed {
        logic [CODE_W-1:0] prefix_code;
        logic [SYM_W-1:0]  next_symbol;
        logic              flush_pair;
        logic              string_end;
        logic              dict_full;
    } pair_t;

    // lz78 predictor plus the queue of pairs still owed by the block
    class pair_tracker;
        bit [CODE_W-1:0] phrase_code [bit [KEY_W-1:0]];
        bit [CODE_W-1:0] match_code = '0;
        int unsigned     next_code  = 1;
        int unsigned     code_limit = 32'(CODE_LIMIT_RST);
        pair_t           expected_pairs [$];
        int unsigned     errors = 0;

        function void restart();
            phrase_code.delete();
            match_code = '0;
            next_code  = 1;
        endfunction

        function void set_limit(bit [CODE_W-1:0] value);
            code_limit = 32'(value);
        endfunction

        function int unsigned pending();
            return expected_pairs.size();
        endfunction

        // advance the encoder by one accepted byte
        function void note_symbol(bit [SYM_W-1:0] sym, bit last);
            bit [KEY_W-1:0] key;
            pair_t          p;
            bit             grow;
            key = {match_code, sym};
            if (phrase_code.exists(key)) begin
                match_code = phrase_code[key];
                if (last) begin
                    // pending match flushed at string end
                    p = {match_code, SYM_W'(0), 1'b1, 1'b1, 1'b0};
                    expected_pairs = {expected_pairs, p};
                    restart();
                end
            end else begin
                grow = (next_code <= code_limit) && (next_code <= LZE_DICT_ENTRIES) &&
                       (next_code <= MAX_CODE);
                p = {match_code, sym, 1'b0, last, !grow};
                expected_pairs = {expected_pairs, p};
                if (grow) begin
                    phrase_code[key] = CODE_W'(next_code);
                    next_code++;
                end
                match_code = '0;
                if (last) restart();
            end
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_pair(pair_t got);
            pair_t want;
            if (expected_pairs.size() == 0) begin
                $error("unexpected pair: prefix_code %0d next_symbol %0d",
                       got.prefix_code, got.next_symbol);
                errors++;
            end else begin
                want = expected_pairs.pop_front();
                compare_field("prefix_code", 16'(want.prefix_code), 16'(got.prefix_code));
                compare_field("next_symbol", 16'(want.next_symbol), 16'(got.next_symbol));
                compare_field("flush_pair",  16'(want.flush_pair),  16'(got.flush_pair));
                compare_field("string_end",  16'(want.string_end),  16'(got.string_end));
                compare_field("dict_full",   16'(want.dict_full),   16'(got.dict_full));
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CODE_W-1:0] cfg_wdata;

    lz78e_sym_if  sym_if ();
    lz78e_pair_if pair_if ();

    lz78_encoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_sym_ch    (sym_if),
        .o_pair_ch   (pair_if)
    );

    pair_tracker tracker;

    // idling knobs, percent of cycles
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;

    int unsigned items_sent = 0;
    int unsigned strings_done = 0;
    int unsigned cycle_count = 0;

    // free running clock, 12 ns period
    always #6 i_clk = ~i_clk;

    // sink side: random back pressure on the pair channel
    always @(posedge i_clk) begin
        pair_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // monitor: every transaction on either channel is seen at the edge that accepts it
    always @(posedge i_clk) begin : monitor
        pair_t got;
        if (i_rst_n) begin
            if (sym_if.valid && sym_if.ready) begin
                tracker.note_symbol(sym_if.symbol, sym_if.last_symbol);
                if (sym_if.last_symbol) strings_done++;
            end
            if (pair_if.valid && pair_if.ready) begin
                got = {pair_if.prefix_code, pair_if.next_symbol, pair_if.flush_pair,
                       pair_if.string_end, pair_if.dict_full};
                tracker.check_pair(got);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // one byte transaction, with an optional random idle gap ahead of it
    task automatic send_byte(input logic [SYM_W-1:0] sym, input logic last);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            sym_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sym_if.valid       <= 1'b1;
        sym_if.symbol      <= sym;
        sym_if.last_symbol <= last;
        do @(posedge i_clk); while (!sym_if.ready);
        items_sent++;
    endtask

    // stop sending and let every owed pair come out
    task automatic wait_for_results();
        if (sym_if.valid) sym_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // code_limit is written only once the block has gone quiet
    task automatic write_code_limit(input logic [CODE_W-1:0] value);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tracker.set_limit(value);
    endtask

    task automatic send_random_string(input int len);
        logic [SYM_W-1:0] alphabet [4];
        int               n_sym;
        int               i;
        // small alphabets make the matches grow long, full bytes exercise every bit
        n_sym = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 4);
        for (i = 0; i < 4; i++) alphabet[i] = SYM_W'($urandom);
        for (i = 0; i < len; i++) begin
            send_byte((n_sym == 0) ? SYM_W'($urandom) : alphabet[$urandom_range(n_sym - 1)],
                      i == len - 1);
        end
    endtask

    function automatic logic [CODE_W-1:0] pick_limit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CODE_W'(1);
            2:       return CODE_W'(2);
            3:       return CODE_W'($urandom_range(3, 8));
            4:       return CODE_W'($urandom_range(9, 40));
            5:       return CODE_W'(4095);
            6:       return CODE_LIMIT_RST;
            7:       return '1;
            8:       return CODE_W'($urandom);
            default: return CODE_W'($urandom_range(41, 300));
        endcase
    endfunction

    initial begin
        int unsigned random_start;
        int          phase;
        int          r;
        bit          pressed;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        sym_if.valid       = 1'b0;
        sym_if.symbol      = '0;
        sym_if.last_symbol = 1'b0;
        tracker = new;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: lone byte, all ones
        send_byte(8'hFF, 1'b1);
        // repeated zero byte ends in a flush of code 1
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // alternating pattern, match grows and ends in a flush of code 3
        repeat (2) begin
            send_byte(8'h55, 1'b0);
            send_byte(8'hAA, 1'b0);
        end
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        // ordinary last pair whose byte is zero, unlike a flush
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // zero limit: no code is ever issued
        write_code_limit('0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h81, 1'b1);
        // limit one: dictionary freezes after the first code
        write_code_limit(CODE_W'(1));
        send_byte(8'h33, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h33, 1'b1);
        // limit two
        write_code_limit(CODE_W'(2));
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h01, 1'b1);

        // one-byte strings carry the epoch tag through its wrap and clearing pass
        while (strings_done < MIN_STRINGS) send_byte(SYM_W'($urandom), 1'b1);

        // random strings across idling modes and limits
        random_start = items_sent;
        phase = 0;
        pressed = 1'b0;
        while (items_sent - random_start < RANDOM_ITEMS || phase < 4) begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
                default: begin src_idle_pct = 37; snk_stall_pct = 37; end
            endcase
            write_code_limit(pick_limit());
            repeat (STRINGS_PER_PHASE) begin
                r = $urandom_range(99);
                if (r < 50) send_random_string($urandom_range(1, 3));
                else if (r < 85) send_random_string($urandom_range(4, 12));
                else send_random_string($urandom_range(13, 48));
                // the first time, and now and then after that, the sender holds off until the block has drained
                if (!pressed || $urandom_range(15) == 0) begin
                    wait_for_results();
                    pressed = 1'b1;
                end
            end
            phase++;
        end

        // drain, then give the block its latency before the verdict
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/lz78e_pkg.sv
rtl/lz78e_ifs.sv
rtl/lz78e_ram.sv
rtl/lz78e_cell.sv
rtl/lz78_encoder_unit.sv
rtl/lz78e_checker.sv
verif/tb.sv
